// ===== rtl/idb_pkg.sv =====
// ----------------------------------------------------------------------------
// idb_pkg: shared types for the indexed deque buffer
// Action and status codes, beat structs and the shift command between the
// list controller and the cell chain.
// ----------------------------------------------------------------------------
package idb_pkg;

  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_AT    = 3'd2,
    ACT_POP_FRONT = 3'd3,
    ACT_POP_BACK  = 3'd4,
    ACT_POP_AT    = 3'd5,
    ACT_REVERSE   = 3'd6,
    ACT_CLEAR     = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    action_e     action;
    logic [4:0]  position;
    logic [31:0] item_value;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] removed_value;
    status_e     status;
    logic [4:0]  entry_count;
  } out_beat_t;

  // shift command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic remove;
  } shift_cmd_t;

endpackage

// ===== rtl/idb_cell.sv =====
// ----------------------------------------------------------------------------
// idb_cell: one storage cell of the list chain
// Holds one data word; takes its left neighbor, the new word or its right
// neighbor depending on the shift command and its own place in the chain.
// ----------------------------------------------------------------------------
module idb_cell
  import idb_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 4,
  parameter int CELL_IDX   = 0
) (
  input  logic                  clk_i,
  input  shift_cmd_t            cmd_i,
  input  logic [IDX_W-1:0]      tgt_i,
  input  logic [DATA_WIDTH-1:0] new_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.insert) begin
      if (MyIdx > tgt_i) begin
        data_d = left_i;
      end else if (MyIdx == tgt_i) begin
        data_d = new_i;
      end
    end else if (cmd_i.remove && (MyIdx >= tgt_i)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/idb_ctrl.sv =====
// ----------------------------------------------------------------------------
// idb_ctrl: list controller
// Keeps count and orientation, checks each action and maps the logical
// index to a physical cell for the shift command.
// ----------------------------------------------------------------------------
module idb_ctrl
  import idb_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  in_beat_t                    beat_i,
  output shift_cmd_t                  cmd_o,
  output logic [$clog2(CAPACITY)-1:0] tgt_o,
  output status_e                     status_o,
  output logic [$clog2(CAPACITY+1)-1:0] count_o
);

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int W     = (CW > 5) ? CW : 5;

  logic [CW-1:0] count_q, count_d;
  logic          rev_q, rev_d;

  logic [W-1:0]  cnt_w, pos_w, k, phys;
  shift_cmd_t    cmd;
  status_e       status;

  assign cnt_w = W'(count_q);
  assign pos_w = W'(beat_i.position);

  always_comb begin
    cmd     = '0;
    status  = ST_OK;
    count_d = count_q;
    rev_d   = rev_q;
    k       = '0;
    phys    = '0;
    unique case (beat_i.action) inside
      ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
        if (beat_i.action == ACT_INS_FRONT) begin
          k = '0;
        end else if (beat_i.action == ACT_INS_BACK) begin
          k = cnt_w;
        end else begin
          k = pos_w;
        end
        if (k > cnt_w) begin
          status = ST_RANGE;
        end else if (cnt_w >= W'(CAPACITY)) begin
          status = ST_FULL;
        end else begin
          cmd.insert = 1'b1;
          phys       = rev_q ? (cnt_w - k) : k;
          count_d    = count_q + CW'(1);
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        k = (beat_i.action == ACT_POP_FRONT) ? '0 : (cnt_w - W'(1));
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else begin
          cmd.remove = 1'b1;
          phys       = rev_q ? (cnt_w - W'(1) - k) : k;
          count_d    = count_q - CW'(1);
        end
      end
      ACT_POP_AT: begin
        k = pos_w;
        if (k >= cnt_w) begin
          status = ST_RANGE;
        end else begin
          cmd.remove = 1'b1;
          phys       = rev_q ? (cnt_w - W'(1) - k) : k;
          count_d    = count_q - CW'(1);
        end
      end
      ACT_REVERSE: begin
        rev_d = ~rev_q;
      end
      ACT_CLEAR: begin
        count_d = '0;
        rev_d   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rev_q   <= 1'b0;
    end else if (accept_i) begin
      count_q <= count_d;
      rev_q   <= rev_d;
    end
  end

  assign cmd_o.insert = cmd.insert & accept_i;
  assign cmd_o.remove = cmd.remove & accept_i;
  assign tgt_o        = phys[IDX_W-1:0];
  assign status_o     = status;
  assign count_o      = count_d;

endmodule

// ===== rtl/indexed_deque_buffer_top.sv =====
// ----------------------------------------------------------------------------
// indexed_deque_buffer_top: bounded ordered list of data words
// Insert and remove at front, back or any index, reverse and clear, built
// as a chain of cells that all shift at once.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+----------------------------------
//  in      | in  | in_valid_i / in_ready_o | in_beat_i  (action, position,
//          |     |                        |            item_value)
//  out     | out | out_valid_o/out_ready_i | out_beat_o (removed_value,
//          |     |                        |            status, entry_count)
//
//  every action finishes in the cycle it is accepted: the whole cell chain
//  shifts in parallel, and the result beat is registered and shows up in the following cycle
//  a new beat is taken in every cycle as long as the result register is
//  empty or being drained, so the rate is one beat per cycle
//  reset clears the count and orientation; the cells themselves are not
//  cleared, only cells below the count are ever read
//  a stalled output holds its beat and blocks input until it is taken
// ----------------------------------------------------------------------------
module indexed_deque_buffer_top
  import idb_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);

  logic                  accept;
  shift_cmd_t            cmd;
  logic [IDX_W-1:0]      tgt;
  status_e               status;
  logic [CW-1:0]         count_nxt;
  logic [DATA_WIDTH-1:0] new_word;

  // cell outputs, one per place in the chain
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

  logic      out_valid_q;
  out_beat_t out_beat_q, out_beat_d;

  // a beat enters whenever the result register is free this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // data word kept to the stored width
  assign new_word = DATA_WIDTH'(in_beat_i.item_value);

  idb_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .beat_i   (in_beat_i),
    .cmd_o    (cmd),
    .tgt_o    (tgt),
    .status_o (status),
    .count_o  (count_nxt)
  );

  // chain of cells: cell 0 is the physical front, the last cell has no
  // right neighbor and just keeps its own word on a remove
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;

    if (i == 0) begin : g_first
      assign left_w = new_word;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    idb_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .CELL_IDX   (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .tgt_i   (tgt),
      .new_i   (new_word),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[i])
    );
  end

  // result beat: removed word is read from the target cell before the shift
  always_comb begin
    out_beat_d.removed_value = cmd.remove ? 32'(cell_data[tgt]) : '0;
    out_beat_d.status        = status;
    out_beat_d.entry_count   = 5'(count_nxt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_beat_q <= out_beat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for indexed_deque_buffer_top
// Drives action beats through the valid/ready input, mirrors the list in a
// behavioral shadow (cells, count, orientation) and checks every result beat
// field by field, under random idling on both sides and forced back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import idb_pkg::*;

  localparam int LIST_CAP    = 16;
  localparam int QUIET_LIMIT = 2000;  // cycles with no beat on either side
  localparam int LONG_HOLD   = 80;    // forced receiver stall length
  localparam int HOLD_AFTER  = 150;   // results seen before the forced stall

  // one pending input beat, optionally held back until all earlier results are back
  typedef struct {
    in_beat_t beat;
    bit       drain_first;
  } stim_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_beat_t  in_beat_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_beat_t out_beat_o;

  stim_t     pending_q[$];
  out_beat_t expected_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent_cnt      = 0;  // blocking, owned by the driver
  int rcv_cnt       = 0;  // nonblocking, owned by the monitor
  int mismatches    = 0;
  int quiet_cycles  = 0;
  int hold_left     = 0;
  bit long_hold_done = 1'b0;

  // shadow copy of the list
  logic [31:0] list_cells[LIST_CAP];
  int          list_len  = 0;
  bit          list_flip = 1'b0;

  indexed_deque_buffer_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  // 2 time unit clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // list shadow: applies one action and returns the result beat it should give
  // logical index k sits in cell k, or in cell len-1-k while flipped
  // --------------------------------------------------------------------------
  task automatic apply_action(input in_beat_t b, output out_beat_t r);
    int k;
    int p;
    int i;
    r = '0;
    r.status = ST_OK;
    k = 0;
    case (b.action)
      ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
        if (b.action == ACT_INS_FRONT) k = 0;
        else if (b.action == ACT_INS_BACK) k = list_len;
        else k = int'(b.position);
        // range check wins over the full check
        if (k > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= LIST_CAP) begin
          r.status = ST_FULL;
        end else begin
          p = list_flip ? list_len - k : k;
          for (i = list_len; i > p; i--) list_cells[i] = list_cells[i-1];
          list_cells[p] = b.item_value;
          list_len++;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK, ACT_POP_AT: begin
        if (b.action == ACT_POP_AT) begin
          k = int'(b.position);
          // also covers popping by index from an empty list
          if (k >= list_len) r.status = ST_RANGE;
        end else if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          k = (b.action == ACT_POP_FRONT) ? 0 : list_len - 1;
        end
        if (r.status == ST_OK) begin
          p = list_flip ? list_len - 1 - k : k;
          r.removed_value = list_cells[p];
          for (i = p; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end
      end
      ACT_REVERSE: begin
        list_flip = !list_flip;
      end
      default: begin
        // clear also restores natural order
        list_len  = 0;
        list_flip = 1'b0;
      end
    endcase
    r.entry_count = 5'(list_len);
  endtask

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_item(input action_e act, input logic [4:0] pos,
                          input logic [31:0] val, input bit drain_first);
    stim_t s;
    s.beat.action     = act;
    s.beat.position   = pos;
    s.beat.item_value = val;
    s.drain_first     = drain_first;
    pending_q.push_back(s);
  endtask

  // random walk in segments that lean toward filling or toward draining,
  // so the list regularly reaches both full and empty
  task automatic add_random(input int n, input bit with_pauses);
    int          ins_share;
    int          r;
    action_e     act;
    logic [4:0]  pos;
    logic [31:0] val;
    bit          pause;
    ins_share = 45;
    for (int j = 0; j < n; j++) begin
      pause = 1'b0;
      if (j % 40 == 0) begin
        ins_share = $urandom_range(1) ? 65 : 28;
        pause = with_pauses;
      end
      r = $urandom_range(99);
      if (r < 3) act = ACT_CLEAR;
      else if (r < 10) act = ACT_REVERSE;
      else if (r < 10 + ins_share) act = action_e'($urandom_range(2));
      else act = action_e'($urandom_range(5, 3));
      // mostly indexes that can land inside the list, sometimes way out
      if ($urandom_range(99) < 85) pos = 5'($urandom_range(16));
      else pos = 5'($urandom_range(31));
      r = $urandom_range(99);
      if (r < 8) val = '0;
      else if (r < 16) val = '1;
      else val = $urandom;
      add_item(act, pos, val, pause);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || sent_cnt != rcv_cnt);
  endtask

  // --------------------------------------------------------------------------
  // driver: presents pending beats, holds valid and payload until accepted
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_proc
    stim_t nxt;
    bit    took;
    bit    offer;
    if (rst_ni) begin
      took = in_valid_i && in_ready_o;
      if (took) sent_cnt = sent_cnt + 1;
      if (!in_valid_i || took) begin
        offer = 1'b0;
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          // a marked beat waits until every result so far has come back
          if (!pending_q[0].drain_first || sent_cnt == rcv_cnt) offer = 1'b1;
        end
        if (offer) begin
          nxt = pending_q.pop_front();
          in_beat_i <= nxt.beat;
        end
        in_valid_i <= offer;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random ready, plus one long forced stall so the result
  // register stays full and the input side backs up
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!long_hold_done && rcv_cnt >= HOLD_AFTER) begin
        hold_left      = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks result beats first, then predicts from the input beat
  // taken on the same edge, so ordering within the step never matters
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_proc
    out_beat_t want;
    out_beat_t pred;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        rcv_cnt <= rcv_cnt + 1;
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result beat: expected none, got %h",
                   $time, out_beat_o);
        end else begin
          want = expected_q.pop_front();
          if (out_beat_o.removed_value !== want.removed_value) begin
            mismatches++;
            $display("%0t removed_value mismatch: expected %h, got %h",
                     $time, want.removed_value, out_beat_o.removed_value);
          end
          if (out_beat_o.status !== want.status) begin
            mismatches++;
            $display("%0t status mismatch: expected %0d, got %0d",
                     $time, want.status, out_beat_o.status);
          end
          if (out_beat_o.entry_count !== want.entry_count) begin
            mismatches++;
            $display("%0t entry_count mismatch: expected %0d, got %0d",
                     $time, want.entry_count, out_beat_o.entry_count);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        apply_action(in_beat_i, pred);
        expected_q.push_back(pred);
      end
    end
  end

  // watchdog on beat activity
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequence: reset, directed corner cases, then three random phases
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // phase 1: sender idles lightly, receiver heavily
    send_idle_pct = 28;
    recv_idle_pct = 61;

    // everything on an empty list
    add_item(ACT_POP_FRONT, 5'd0, 32'h0, 1'b0);
    add_item(ACT_POP_BACK, 5'd0, 32'h0, 1'b0);
    add_item(ACT_POP_AT, 5'd0, 32'h0, 1'b0);
    add_item(ACT_INS_AT, 5'd1, 32'h1234_5678, 1'b0);
    add_item(ACT_REVERSE, 5'd0, 32'h0, 1'b0);
    // fill to capacity while flipped, mixing all insert kinds
    for (int i = 0; i < LIST_CAP; i++) begin
      case (i % 3)
        0: add_item(ACT_INS_FRONT, 5'd0, (i == 0) ? 32'h0 : $urandom, 1'b0);
        1: add_item(ACT_INS_BACK, 5'd0, (i == 1) ? 32'hFFFF_FFFF : $urandom, 1'b0);
        // insert at index equal to count appends
        default: add_item(ACT_INS_AT, (i == 2) ? 5'(i) : 5'(i / 2), $urandom, 1'b0);
      endcase
    end
    add_item(ACT_INS_BACK, 5'd0, 32'hDEAD_BEEF, 1'b0);  // full
    add_item(ACT_INS_AT, 5'd17, 32'hDEAD_BEEF, 1'b0);   // range beats full
    add_item(ACT_POP_AT, 5'd31, 32'h0, 1'b0);
    add_item(ACT_POP_AT, 5'd15, 32'h0, 1'b0);
    add_item(ACT_REVERSE, 5'd0, 32'h0, 1'b0);
    add_item(ACT_POP_FRONT, 5'd0, 32'h0, 1'b0);
    add_item(ACT_POP_BACK, 5'd0, 32'h0, 1'b0);
    add_item(ACT_CLEAR, 5'd0, 32'h0, 1'b0);
    add_item(ACT_POP_FRONT, 5'd0, 32'h0, 1'b0);

    add_random(290, 1'b0);
    wait_drained();

    // phase 2: roles swapped, some segments start on a drained block
    send_idle_pct = 61;
    recv_idle_pct = 28;
    add_random(320, 1'b1);
    wait_drained();

    // phase 3: full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(320, 1'b0);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/idb_pkg.sv
rtl/idb_cell.sv
rtl/idb_ctrl.sv
rtl/indexed_deque_buffer_top.sv
verif/testbench.sv
